// ===== hw/rtl/bech32_stream_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Bech32 stream encoder assertion macros
// Shared wrappers for the concurrent assertions of the encoder checker.
// ----------------------------------------------------------------------------
`ifndef BECH32_STREAM_ENCODER_MACROS_SVH
`define BECH32_STREAM_ENCODER_MACROS_SVH

// Assertion that is switched off while the reset is asserted.
`define B32SE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked during reset.
`define B32SE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/b32se_pkg.sv =====
// ----------------------------------------------------------------------------
// Bech32 stream encoder package
// Types, constants and helper functions shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b32se_pkg;

  localparam int unsigned HrpWidth     = 63;
  localparam int unsigned MaxHrpLength = 8;
  localparam int unsigned CsumWidth    = 30;

  localparam logic [3:0] AddrHrpChars  = 4'h0;
  localparam logic [3:0] AddrHrpLength = 4'h8;

  localparam logic [6:0] CharSeparator = 7'h31;

  localparam logic [CsumWidth-1:0] Gen0 = 30'h3b6a57b2;
  localparam logic [CsumWidth-1:0] Gen1 = 30'h26508e6d;
  localparam logic [CsumWidth-1:0] Gen2 = 30'h1ea119fa;
  localparam logic [CsumWidth-1:0] Gen3 = 30'h3d4233dd;
  localparam logic [CsumWidth-1:0] Gen4 = 30'h2a1462b3;

  typedef enum logic [2:0] {
    POLY_HOLD,
    POLY_SEED,
    POLY_FOLD,
    POLY_FOLD_FINAL,
    POLY_SHIFT
  } poly_op_e;

  typedef struct packed {
    poly_op_e   op;
    logic [4:0] sym;
  } poly_ctrl_t;

  function automatic logic [CsumWidth-1:0] polymod_fold(input logic [CsumWidth-1:0] csum,
                                                        input logic [4:0] sym);
    logic [4:0]           top;
    logic [CsumWidth-1:0] res;
    top = csum[29:25];
    res = {csum[24:0], 5'b00000} ^ {25'd0, sym};
    if (top[0]) res = res ^ Gen0;
    if (top[1]) res = res ^ Gen1;
    if (top[2]) res = res ^ Gen2;
    if (top[3]) res = res ^ Gen3;
    if (top[4]) res = res ^ Gen4;
    return res;
  endfunction

  function automatic logic [6:0] charset(input logic [4:0] sym);
    logic [7:0] ch;
    case (sym)
      5'd0:  ch = "q";
      5'd1:  ch = "p";
      5'd2:  ch = "z";
      5'd3:  ch = "r";
      5'd4:  ch = "y";
      5'd5:  ch = "9";
      5'd6:  ch = "x";
      5'd7:  ch = "8";
      5'd8:  ch = "g";
      5'd9:  ch = "f";
      5'd10: ch = "2";
      5'd11: ch = "t";
      5'd12: ch = "v";
      5'd13: ch = "d";
      5'd14: ch = "w";
      5'd15: ch = "0";
      5'd16: ch = "s";
      5'd17: ch = "3";
      5'd18: ch = "j";
      5'd19: ch = "n";
      5'd20: ch = "5";
      5'd21: ch = "4";
      5'd22: ch = "k";
      5'd23: ch = "h";
      5'd24: ch = "c";
      5'd25: ch = "e";
      5'd26: ch = "6";
      5'd27: ch = "m";
      5'd28: ch = "u";
      5'd29: ch = "a";
      5'd30: ch = "7";
      default: ch = "l";
    endcase
    return ch[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bech32_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// Bech32 stream encoder
// Turns a stream of message bytes into a Bech32 string, one ASCII character
// per output transaction, with the prefix, separator and six-character
// checksum.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  data_byte_i, last_byte_i
// output    out        out_valid_o/out_stall_i  out_char_o, last_char_o
// config    in         APB write and read       hrp_chars, hrp_length
//
// A byte is accepted, then split into 5-bit symbols, each folded into the
// checksum as its character is sent; no byte is taken until under five bits
// remain. The first byte of a message is preceded by the prefix (L characters):
// high-bit folds, a zero fold, low-bit folds with each character, separator.
// The last byte adds a pad symbol if bits remain, six zero folds and six
// characters. Whenever a character is due while the output register is held,
// the sequencer waits. Reset clears the control state, not the prefix shifter or output character.
// ----------------------------------------------------------------------------
`default_nettype none

module bech32_stream_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       out_char_o,
  output logic             last_char_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StHrpHi = 3'd1;
  localparam logic [2:0] StSep   = 3'd2;
  localparam logic [2:0] StHrpLo = 3'd3;
  localparam logic [2:0] StOne   = 3'd4;
  localparam logic [2:0] StData  = 3'd5;
  localparam logic [2:0] StZero  = 3'd6;
  localparam logic [2:0] StCsum  = 3'd7;

  logic [b32se_pkg::HrpWidth-1:0] hrp_chars_q;
  logic [3:0]                     hrp_len_q;
  logic [3:0]                     len_eff;

  logic [2:0]                     state_q, state_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic                           in_msg_q, in_msg_d;
  logic                           last_q, last_d;
  logic [11:0]                    acc_q, acc_d;
  logic [3:0]                     pend_q, pend_d;
  logic [b32se_pkg::HrpWidth-1:0] hrp_sr_q, hrp_sr_d;

  logic                           out_valid_q;
  logic [6:0]                     out_char_q;
  logic                           last_char_q;

  logic                           slot_free;
  logic                           emit;
  logic [6:0]                     emit_char;
  logic                           emit_last;
  logic                           in_accept;
  logic                           cfg_write;

  logic [3:0]                     keep_mask;
  logic [2:0]                     sym_shift;
  logic [2:0]                     pad_shift;
  logic [4:0]                     sym_data;
  logic [4:0]                     sym_pad;
  logic [3:0]                     pend_after;

  b32se_pkg::poly_ctrl_t          poly_ctrl;
  logic [4:0]                     poly_top;

  b32se_polymod u_polymod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (poly_ctrl),
    .top_o  (poly_top)
  );

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hrp_chars_q <= 63'd25442;
      hrp_len_q   <= 4'd2;
    end else if (cfg_write) begin
      if (paddr == b32se_pkg::AddrHrpChars) begin
        hrp_chars_q <= pwdata[62:0];
      end
      if (paddr == b32se_pkg::AddrHrpLength) begin
        hrp_len_q <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      b32se_pkg::AddrHrpChars:  prdata = {1'b0, hrp_chars_q};
      b32se_pkg::AddrHrpLength: prdata = {60'd0, hrp_len_q};
      default:                  prdata = 64'd0;
    endcase
  end

  assign len_eff = (hrp_len_q > 4'(b32se_pkg::MaxHrpLength)) ?
                   4'(b32se_pkg::MaxHrpLength) : hrp_len_q;

  // Bit regrouping helpers.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign keep_mask  = 4'((5'd1 << pend_q) - 5'd1);
  assign sym_shift  = 3'(pend_q - 4'd5);
  assign pad_shift  = 3'(4'd5 - pend_q);
  assign sym_data   = 5'(acc_q >> sym_shift);
  assign sym_pad    = 5'(acc_q << pad_shift);
  assign pend_after = pend_q - 4'd5;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    in_msg_d  = in_msg_q;
    last_d    = last_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    hrp_sr_d  = hrp_sr_q;
    emit      = 1'b0;
    emit_char = 7'd0;
    emit_last = 1'b0;
    poly_ctrl = '{op: b32se_pkg::POLY_HOLD, sym: 5'd0};

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          acc_d  = {acc_q[3:0] & keep_mask, data_byte_i};
          pend_d = pend_q + 4'd8;
          last_d = last_byte_i;
          if (!in_msg_q) begin
            hrp_sr_d  = hrp_chars_q;
            cnt_d     = 4'd0;
            poly_ctrl = '{op: b32se_pkg::POLY_SEED, sym: 5'd0};
            state_d   = StHrpHi;
          end else begin
            state_d = StData;
          end
        end
      end
      StHrpHi: begin
        if (cnt_q < len_eff) begin
          poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: {3'b000, hrp_sr_q[6:5]}};
          hrp_sr_d  = hrp_sr_q >> 8;
          cnt_d     = cnt_q + 4'd1;
        end else begin
          state_d = StSep;
        end
      end
      StSep: begin
        poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: 5'd0};
        hrp_sr_d  = hrp_chars_q;
        cnt_d     = 4'd0;
        state_d   = StHrpLo;
      end
      StHrpLo: begin
        if (cnt_q < len_eff) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = hrp_sr_q[6:0];
            poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: hrp_sr_q[4:0]};
            hrp_sr_d  = hrp_sr_q >> 8;
            cnt_d     = cnt_q + 4'd1;
          end
        end else begin
          state_d = StOne;
        end
      end
      StOne: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = b32se_pkg::CharSeparator;
          in_msg_d  = 1'b1;
          state_d   = StData;
        end
      end
      StData: begin
        if (pend_q >= 4'd5) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = b32se_pkg::charset(sym_data);
            poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: sym_data};
            pend_d    = pend_after;
            if ((pend_after < 4'd5) && !last_q) begin
              state_d = StIdle;
            end
          end
        end else if (pend_q != 4'd0) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = b32se_pkg::charset(sym_pad);
            poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: sym_pad};
            pend_d    = 4'd0;
            acc_d     = 12'd0;
          end
        end else begin
          cnt_d   = 4'd0;
          state_d = StZero;
        end
      end
      StZero: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          poly_ctrl = '{op: b32se_pkg::POLY_FOLD_FINAL, sym: 5'd0};
          cnt_d     = 4'd0;
          state_d   = StCsum;
        end else begin
          poly_ctrl = '{op: b32se_pkg::POLY_FOLD, sym: 5'd0};
        end
      end
      StCsum: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = b32se_pkg::charset(poly_top);
          cnt_d     = cnt_q + 4'd1;
          if (cnt_q == 4'd5) begin
            emit_last = 1'b1;
            poly_ctrl = '{op: b32se_pkg::POLY_SEED, sym: 5'd0};
            in_msg_d  = 1'b0;
            acc_d     = 12'd0;
            pend_d    = 4'd0;
            last_d    = 1'b0;
            cnt_d     = 4'd0;
            state_d   = StIdle;
          end else begin
            poly_ctrl = '{op: b32se_pkg::POLY_SHIFT, sym: 5'd0};
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= 4'd0;
      in_msg_q <= 1'b0;
      last_q   <= 1'b0;
      acc_q    <= 12'd0;
      pend_q   <= 4'd0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      in_msg_q <= in_msg_d;
      last_q   <= last_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hrp_sr_q <= hrp_sr_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= emit_char;
      last_char_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_char_q;

endmodule

`default_nettype wire

// ===== hw/rtl/b32se_polymod.sv =====
// ----------------------------------------------------------------------------
// Bech32 polymod checksum register
// Folds one 5-bit symbol per cycle while told to fold, else seeds, holds or shifts the finished checksum out.
// ----------------------------------------------------------------------------
`default_nettype none

module b32se_polymod (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire b32se_pkg::poly_ctrl_t ctrl_i,
  output logic [4:0]                top_o
);

  logic [b32se_pkg::CsumWidth-1:0] csum_q, csum_d;
  logic [b32se_pkg::CsumWidth-1:0] folded;

  assign folded = b32se_pkg::polymod_fold(csum_q, ctrl_i.sym);

  always_comb begin
    csum_d = csum_q;
    case (ctrl_i.op)
      b32se_pkg::POLY_SEED:       csum_d = 30'd1;
      b32se_pkg::POLY_FOLD:       csum_d = folded;
      b32se_pkg::POLY_FOLD_FINAL: csum_d = folded ^ 30'd1;
      b32se_pkg::POLY_SHIFT:      csum_d = {csum_q[24:0], 5'b00000};
      default:                    csum_d = csum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= 30'd1;
    end else begin
      csum_q <= csum_d;
    end
  end

  assign top_o = csum_q[29:25];

endmodule

`default_nettype wire

// ===== hw/rtl/b32se_checker.sv =====
// ----------------------------------------------------------------------------
// Bech32 stream encoder checker
// Port-level assertions on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bech32_stream_encoder_macros.svh"

module b32se_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [6:0] out_char_o,
  input wire logic       last_char_o,
  input wire logic       pready
);

  // A held character must not change until the transaction completes.
  `B32SE_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_char_o) && $stable(last_char_o)), "output changed while stalled")

  // An accepted byte occupies the encoder for at least the following cycle.
  `B32SE_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "encoder accepted back-to-back bytes")

  // No character is offered while the reset is applied.
  `B32SE_ASSERT_ALWAYS(a_reset_quiet, clk_i, (!rst_ni) |-> (!out_valid_o), "output valid during reset")

  // The configuration port never inserts wait states.
  `B32SE_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni |-> pready, "configuration port not ready")

endmodule

bind bech32_stream_encoder b32se_checker u_b32se_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .last_char_o (last_char_o),
  .pready      (pready)
);

`default_nettype wire
